// File: hw/rtl/dxt_pkg.sv
// Shared types, constants and arithmetic helpers for the DXT block decoder.
package dxt_pkg;

  localparam int MAX_IMAGE_WIDTH = 4096;

  localparam int WIDTH_W = 13;
  localparam int IDX_W   = 24;
  localparam int TEXEL_W = 32;

  localparam logic [1:0] MODE_DXT1 = 2'd0;
  localparam logic [1:0] MODE_DXT3 = 2'd1;
  localparam logic [1:0] MODE_DXT5 = 2'd2;

  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_LAST  = 2'd3;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(4);
  localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAX_IMAGE_WIDTH);

  // Reciprocals of 7 and 5 scaled by 2^15, rounded up; exact for sums up to 7*255.
  localparam logic [12:0] DIV7_RECIP = 13'd4682;
  localparam logic [12:0] DIV5_RECIP = 13'd6554;

  typedef logic [3:0][TEXEL_W-1:0] palette_t;
  typedef logic [7:0][7:0]         alpha_tab_t;
  typedef logic [5:0][10:0]        alpha_sum_t;

  // Block after palette expansion, with the interpolated alpha sums not yet divided.
  typedef struct packed {
    logic [1:0]       mode;
    logic [63:0]      lo;
    logic [31:0]      sel;
    palette_t         pal;
    logic             alpha_gt;
    logic [7:0]       a0;
    logic [7:0]       a1;
    alpha_sum_t       asum;
    logic [IDX_W-1:0] base;
  } blk_b_t;

  // Fully decoded block, ready to be split into rows.
  typedef struct packed {
    logic [1:0]       mode;
    logic [63:0]      lo;
    logic [31:0]      sel;
    palette_t         pal;
    alpha_tab_t       atab;
    logic [IDX_W-1:0] base;
  } blk_c_t;

  // Weighted sum of two channel values followed by a right shift.
  function automatic logic [7:0] ch_scale(input logic [5:0] a, input logic [5:0] b,
                                          input logic [7:0] wa, input logic [7:0] wb,
                                          input int unsigned sh);
    logic [15:0] s;
    s = 16'(a) * 16'(wa) + 16'(b) * 16'(wb);
    return 8'(s >> sh);
  endfunction

  // Floor division by 7 (eight-point mode) or by 5 (six-point mode).
  function automatic logic [7:0] alpha_div(input logic [10:0] sum, input logic gt);
    logic [23:0] p;
    p = 24'(sum) * 24'(gt ? DIV7_RECIP : DIV5_RECIP);
    return p[22:15];
  endfunction

endpackage

// File: hw/rtl/dxt_block_decoder.sv
// Top level of the DXT1/DXT3/DXT5 4x4 block decoder.
//
// Usage: one item on the in_ channel carries a 16-byte compressed block, its mode
// and the pixel position of its top-left texel. The block comes out on the out_
// channel as four row items, top to bottom, each with four packed RGBA texels,
// the row number, the linear pixel index of its first texel and a last-row flag.
// Both channels use valid/ready; an item moves when both are high.
// cfg_wr_en writes the image width used for pixel indices; widths above
// MAX_IMAGE_WIDTH are clamped. Write it only while the decoder is empty.
// Each accepted block passes the input register, palette stage, alpha stage, row
// sequencer and output register. The row sequencer sends one row per cycle while
// out_ready is high and takes the next block as its last row is loaded. Three
// pipeline stages in front of it keep taking blocks while it works.
// Reset (synchronous, rst_n low) empties every stage and sets the width to 4.
// When out_ready is low the output row holds; the stages fill up behind it and
// in_ready drops once all are full. Nothing is lost or repeated.
module dxt_block_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [dxt_pkg::WIDTH_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_mode,
  input  logic [63:0]                   in_block_lo,
  input  logic [63:0]                   in_block_hi,
  input  logic [11:0]                   in_block_x,
  input  logic [11:0]                   in_block_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_row_index,
  output logic [dxt_pkg::IDX_W-1:0]     out_pixel_index,
  output logic [dxt_pkg::TEXEL_W-1:0]   out_texel0,
  output logic [dxt_pkg::TEXEL_W-1:0]   out_texel1,
  output logic [dxt_pkg::TEXEL_W-1:0]   out_texel2,
  output logic [dxt_pkg::TEXEL_W-1:0]   out_texel3,
  output logic                          out_last_row
);
  import dxt_pkg::*;

  logic [WIDTH_W-1:0] cfg_width_r;
  logic [WIDTH_W-1:0] width_eff;

  logic   b_valid;
  logic   b_ready;
  blk_b_t b_blk;
  logic   c_valid;
  logic   c_ready;
  blk_c_t c_blk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r <= WIDTH_RESET;
    end else if (cfg_wr_en) begin
      cfg_width_r <= cfg_wr_data;
    end
  end

  assign width_eff = (cfg_width_r > WIDTH_MAX) ? WIDTH_MAX : cfg_width_r;

  dxt_palette u_palette (
    .clk         (clk),
    .rst_n       (rst_n),
    .width       (width_eff),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_mode     (in_mode),
    .in_block_lo (in_block_lo),
    .in_block_hi (in_block_hi),
    .in_block_x  (in_block_x),
    .in_block_y  (in_block_y),
    .b_valid     (b_valid),
    .b_ready     (b_ready),
    .b_blk       (b_blk)
  );

  dxt_alpha u_alpha (
    .clk     (clk),
    .rst_n   (rst_n),
    .b_valid (b_valid),
    .b_ready (b_ready),
    .b_blk   (b_blk),
    .c_valid (c_valid),
    .c_ready (c_ready),
    .c_blk   (c_blk)
  );

  dxt_row_out u_row_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .width           (width_eff),
    .c_valid         (c_valid),
    .c_ready         (c_ready),
    .c_blk           (c_blk),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_row_index   (out_row_index),
    .out_pixel_index (out_pixel_index),
    .out_texel0      (out_texel0),
    .out_texel1      (out_texel1),
    .out_texel2      (out_texel2),
    .out_texel3      (out_texel3),
    .out_last_row    (out_last_row)
  );

endmodule

// File: hw/rtl/dxt_palette.sv
// Input register stage and colour palette / alpha sum / base index stage.
module dxt_palette (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [dxt_pkg::WIDTH_W-1:0]   width,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_mode,
  input  logic [63:0]                   in_block_lo,
  input  logic [63:0]                   in_block_hi,
  input  logic [11:0]                   in_block_x,
  input  logic [11:0]                   in_block_y,
  output logic                          b_valid,
  input  logic                          b_ready,
  output dxt_pkg::blk_b_t               b_blk
);
  import dxt_pkg::*;

  logic        a_valid_r;
  logic [1:0]  a_mode_r;
  logic [63:0] a_lo_r;
  logic [63:0] a_hi_r;
  logic [11:0] a_bx_r;
  logic [11:0] a_by_r;
  logic        a_ready;
  logic        a_move;

  logic        b_valid_r;
  blk_b_t      b_blk_r;
  blk_b_t      b_blk_nxt;

  logic [63:0] colour;
  logic [15:0] c0;
  logic [15:0] c1;
  logic [5:0]  r0, g0, b0, r1, g1, b1;
  logic        four;
  logic [7:0]  a0;
  logic [7:0]  a1;
  logic        gt;
  logic [24:0] row_off;

  assign a_move   = a_valid_r && (!b_valid_r || b_ready);
  assign a_ready  = !a_valid_r || (!b_valid_r || b_ready);
  assign in_ready = a_ready;
  assign b_valid  = b_valid_r;
  assign b_blk    = b_blk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= in_valid;
      end
      if (!b_valid_r || b_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      a_mode_r <= in_mode;
      a_lo_r   <= in_block_lo;
      a_hi_r   <= in_block_hi;
      a_bx_r   <= in_block_x;
      a_by_r   <= in_block_y;
    end
    if (a_move) begin
      b_blk_r <= b_blk_nxt;
    end
  end

  always_comb begin
    colour = (a_mode_r == MODE_DXT1) ? a_lo_r : a_hi_r;
    c0 = colour[15:0];
    c1 = colour[31:16];
    r0 = {1'b0, c0[15:11]};
    g0 = c0[10:5];
    b0 = {1'b0, c0[4:0]};
    r1 = {1'b0, c1[15:11]};
    g1 = c1[10:5];
    b1 = {1'b0, c1[4:0]};
    // Only DXT1 may fall back to the three-colour palette.
    four = (a_mode_r != MODE_DXT1) || (c0 > c1);

    b_blk_nxt.mode = a_mode_r;
    b_blk_nxt.lo   = a_lo_r;
    b_blk_nxt.sel  = colour[63:32];

    b_blk_nxt.pal[0] = {ch_scale(r0, 6'd0, 8'd255, 8'd0, 5), ch_scale(g0, 6'd0, 8'd255, 8'd0, 6),
                        ch_scale(b0, 6'd0, 8'd255, 8'd0, 5), 8'hFF};
    b_blk_nxt.pal[1] = {ch_scale(r1, 6'd0, 8'd255, 8'd0, 5), ch_scale(g1, 6'd0, 8'd255, 8'd0, 6),
                        ch_scale(b1, 6'd0, 8'd255, 8'd0, 5), 8'hFF};
    if (four) begin
      b_blk_nxt.pal[2] = {ch_scale(r0, r1, 8'd170, 8'd85, 5), ch_scale(g0, g1, 8'd170, 8'd85, 6),
                          ch_scale(b0, b1, 8'd170, 8'd85, 5), 8'hFF};
      b_blk_nxt.pal[3] = {ch_scale(r0, r1, 8'd85, 8'd170, 5), ch_scale(g0, g1, 8'd85, 8'd170, 6),
                          ch_scale(b0, b1, 8'd85, 8'd170, 5), 8'hFF};
    end else begin
      b_blk_nxt.pal[2] = {ch_scale(r0, r1, 8'd255, 8'd255, 6),
                          ch_scale(g0, g1, 8'd255, 8'd255, 7),
                          ch_scale(b0, b1, 8'd255, 8'd255, 6), 8'hFF};
      b_blk_nxt.pal[3] = '0;
    end

    a0 = a_lo_r[7:0];
    a1 = a_lo_r[15:8];
    gt = a0 > a1;
    b_blk_nxt.alpha_gt = gt;
    b_blk_nxt.a0       = a0;
    b_blk_nxt.a1       = a1;
    for (int k = 1; k <= 6; k++) begin
      if (gt) begin
        b_blk_nxt.asum[k-1] = 11'(7 - k) * 11'(a0) + 11'(k) * 11'(a1);
      end else if (k <= 4) begin
        b_blk_nxt.asum[k-1] = 11'(5 - k) * 11'(a0) + 11'(k) * 11'(a1);
      end else begin
        b_blk_nxt.asum[k-1] = '0;
      end
    end

    row_off        = 25'(width) * 25'(a_by_r);
    b_blk_nxt.base = IDX_W'(row_off) + IDX_W'(a_bx_r);
  end

endmodule

// File: hw/rtl/dxt_alpha.sv
// Alpha table stage: divides the interpolated DXT5 alpha sums by 7 or 5 and, in six-point mode, adds entries 0 and 255.
module dxt_alpha (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             b_valid,
  output logic             b_ready,
  input  dxt_pkg::blk_b_t  b_blk,
  output logic             c_valid,
  input  logic             c_ready,
  output dxt_pkg::blk_c_t  c_blk
);
  import dxt_pkg::*;

  logic   c_valid_r;
  blk_c_t c_blk_r;
  blk_c_t c_blk_nxt;

  assign b_ready = !c_valid_r || c_ready;
  assign c_valid = c_valid_r;
  assign c_blk   = c_blk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (b_ready) begin
      c_valid_r <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && b_ready) begin
      c_blk_r <= c_blk_nxt;
    end
  end

  always_comb begin
    c_blk_nxt.mode    = b_blk.mode;
    c_blk_nxt.lo      = b_blk.lo;
    c_blk_nxt.sel     = b_blk.sel;
    c_blk_nxt.pal     = b_blk.pal;
    c_blk_nxt.base    = b_blk.base;
    c_blk_nxt.atab[0] = b_blk.a0;
    c_blk_nxt.atab[1] = b_blk.a1;
    for (int k = 1; k <= 6; k++) begin
      if (b_blk.alpha_gt || k <= 4) begin
        c_blk_nxt.atab[k+1] = alpha_div(b_blk.asum[k-1], b_blk.alpha_gt);
      end else if (k == 5) begin
        c_blk_nxt.atab[k+1] = 8'd0;
      end else begin
        c_blk_nxt.atab[k+1] = 8'd255;
      end
    end
  end

endmodule

// File: hw/rtl/dxt_row_out.sv
// Row sequencer: holds one decoded block and emits its four rows through an output register.
module dxt_row_out (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [dxt_pkg::WIDTH_W-1:0]   width,
  input  logic                          c_valid,
  output logic                          c_ready,
  input  dxt_pkg::blk_c_t               c_blk,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_row_index,
  output logic [dxt_pkg::IDX_W-1:0]     out_pixel_index,
  output logic [dxt_pkg::TEXEL_W-1:0]   out_texel0,
  output logic [dxt_pkg::TEXEL_W-1:0]   out_texel1,
  output logic [dxt_pkg::TEXEL_W-1:0]   out_texel2,
  output logic [dxt_pkg::TEXEL_W-1:0]   out_texel3,
  output logic                          out_last_row
);
  import dxt_pkg::*;

  logic                            ser_valid_r;
  blk_c_t                          ser_blk_r;
  logic [1:0]                      row_r;
  logic [IDX_W-1:0]                idx_r;
  logic                            out_load;
  logic                            ser_done;
  logic                            ser_ready;

  logic                            out_valid_r;
  logic [1:0]                      out_row_index_r;
  logic [IDX_W-1:0]                out_pixel_index_r;
  logic [3:0][TEXEL_W-1:0]         out_texel_r;
  logic                            out_last_row_r;
  logic [3:0][TEXEL_W-1:0]         texel_nxt;

  logic [7:0]                      sel_byte;
  logic [3:0]                      tnum;
  logic [5:0]                      abit;
  logic [3:0]                      nib;
  logic [2:0]                      aidx;
  logic [TEXEL_W-1:0]              px;

  // A new row enters the output register when it is empty or being drained.
  assign out_load  = ser_valid_r && (!out_valid_r || out_ready);
  assign ser_done  = out_load && (row_r == ROW_LAST);
  assign ser_ready = !ser_valid_r || ser_done;
  assign c_ready   = ser_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_valid_r <= 1'b0;
      row_r       <= ROW_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      if (ser_ready) begin
        ser_valid_r <= c_valid;
        row_r       <= ROW_FIRST;
      end else if (out_load) begin
        row_r <= row_r + 2'd1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_valid && ser_ready) begin
      ser_blk_r <= c_blk;
      idx_r     <= c_blk.base;
    end else if (out_load) begin
      idx_r <= idx_r + IDX_W'(width);
    end
    if (out_load) begin
      out_row_index_r   <= row_r;
      out_pixel_index_r <= idx_r;
      out_texel_r       <= texel_nxt;
      out_last_row_r    <= (row_r == ROW_LAST);
    end
  end

  always_comb begin
    sel_byte = ser_blk_r.sel[{row_r, 3'b000} +: 8];
    tnum     = '0;
    abit     = '0;
    nib      = '0;
    aidx     = '0;
    px       = '0;
    for (int i = 0; i < 4; i++) begin
      tnum = {row_r, 2'(i)};
      px   = ser_blk_r.pal[sel_byte[2*i +: 2]];
      nib  = ser_blk_r.lo[{tnum, 2'b00} +: 4];
      abit = 6'd16 + 6'(3 * tnum);
      aidx = ser_blk_r.lo[abit +: 3];
      case (ser_blk_r.mode)
        MODE_DXT1: begin
          px = px;
        end
        MODE_DXT3: begin
          px[7:0] = {nib, nib};
        end
        default: begin
          px[7:0] = ser_blk_r.atab[aidx];
        end
      endcase
      texel_nxt[i] = px;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_row_index   = out_row_index_r;
  assign out_pixel_index = out_pixel_index_r;
  assign out_texel0      = out_texel_r[0];
  assign out_texel1      = out_texel_r[1];
  assign out_texel2      = out_texel_r[2];
  assign out_texel3      = out_texel_r[3];
  assign out_last_row    = out_last_row_r;

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_row_r == (out_row_index_r == ROW_LAST)))
    else $error("last_row flag does not match row index");

  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && !out_last_row_r) |=>
      (!out_valid_r || (out_row_index_r == $past(out_row_index_r) + 2'd1)))
    else $error("row after a non-final row is not the next row");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && !out_last_row_r) |=>
      (!out_valid_r || (out_pixel_index_r == $past(out_pixel_index_r) + IDX_W'(width))))
    else $error("pixel index did not advance by the image width");

  a_block_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (row_r != ROW_LAST)) |=> ser_valid_r)
    else $error("block dropped before its last row was emitted");

endmodule
